/* rtl/nfc_pkg.sv */
// ----------------------------------------------------------------------------
// NOR flash command decoder package
// Shared field widths, command codes, phase codes and decoder result type.
// ----------------------------------------------------------------------------
package nfc_pkg;

   localparam int KIND_W = 2;
   localparam int WADDR_W = 19;
   localparam int WORD_W = 16;
   localparam int TICKS_W = 24;
   localparam int CSR_ADDR_W = 5;
   localparam int CSR_DATA_W = 32;

   localparam logic [KIND_W-1:0] KIND_READ = 2'd0;
   localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK = 2'd2;

   localparam logic [2:0] CSR_MANUF = 3'd0;
   localparam logic [2:0] CSR_DEVICE = 3'd1;
   localparam logic [2:0] CSR_PROG_TICKS = 3'd2;
   localparam logic [2:0] CSR_SECT_TICKS = 3'd3;
   localparam logic [2:0] CSR_BLOCK_TICKS = 3'd4;
   localparam logic [2:0] CSR_CHIP_TICKS = 3'd5;

   localparam logic [14:0] UNLOCK_ADDR1 = 15'h5555;
   localparam logic [14:0] UNLOCK_ADDR2 = 15'h2AAA;
   localparam logic [7:0] CMD_UNLOCK1 = 8'hAA;
   localparam logic [7:0] CMD_UNLOCK2 = 8'h55;
   localparam logic [7:0] CMD_PROGRAM = 8'hA0;
   localparam logic [7:0] CMD_ERASE = 8'h80;
   localparam logic [7:0] CMD_ID_ENTRY = 8'h90;
   localparam logic [7:0] CMD_CHIP_ERASE = 8'h10;
   localparam logic [7:0] CMD_SECT_ERASE = 8'h30;
   localparam logic [7:0] CMD_BLOCK_ERASE = 8'h50;

   localparam logic [2:0] STEP_READ = 3'd0;
   localparam logic [2:0] STEP_U1 = 3'd1;
   localparam logic [2:0] STEP_U2 = 3'd2;
   localparam logic [2:0] STEP_PROG = 3'd3;
   localparam logic [2:0] STEP_E1 = 3'd4;
   localparam logic [2:0] STEP_E2 = 3'd5;
   localparam logic [2:0] STEP_E3 = 3'd6;

   localparam logic [1:0] OP_PROG = 2'd0;
   localparam logic [1:0] OP_SECTOR = 2'd1;
   localparam logic [1:0] OP_BLOCK = 2'd2;
   localparam logic [1:0] OP_CHIP = 2'd3;

   typedef struct packed {
      logic       id_mode;
      logic [2:0] step;
   } phase_type;

   typedef struct packed {
      phase_type  phase;
      logic       start;
      logic [1:0] op;
   } dec_type;

endpackage

/* rtl/nfc_array.sv */
// ----------------------------------------------------------------------------
// NOR flash word array
// Single-port-write, single-read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module nfc_array #(
   parameter int ARRAY_WORDS = 524288
) (
   input  logic                              clock,
   input  logic                              wr_en,
   input  logic [$clog2(ARRAY_WORDS)-1:0]    wr_addr,
   input  logic [nfc_pkg::WORD_W-1:0]        wr_data,
   input  logic [$clog2(ARRAY_WORDS)-1:0]    rd_addr,
   output logic [nfc_pkg::WORD_W-1:0]        rd_data
);

   logic [nfc_pkg::WORD_W-1:0] mem [ARRAY_WORDS];
   logic [nfc_pkg::WORD_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/nfc_decode.sv */
// ----------------------------------------------------------------------------
// NOR flash command sequence decoder
// Next command phase and operation start for one bus write.
// ----------------------------------------------------------------------------
module nfc_decode (
   input  nfc_pkg::phase_type              phase,
   input  logic [nfc_pkg::WADDR_W-1:0]     word_address,
   input  logic [nfc_pkg::WORD_W-1:0]      write_data,
   output nfc_pkg::dec_type                dec
);

   logic [14:0] ca;
   logic [7:0]  cd;
   logic        idm;

   assign ca = word_address[14:0];
   assign cd = write_data[7:0];
   assign idm = phase.id_mode;

   always_comb begin
      dec.phase = '{id_mode: 1'b0, step: nfc_pkg::STEP_READ};
      dec.start = 1'b0;
      dec.op = nfc_pkg::OP_PROG;
      unique case (phase.step)
         nfc_pkg::STEP_READ: begin
            if (ca == nfc_pkg::UNLOCK_ADDR1 && cd == nfc_pkg::CMD_UNLOCK1) begin
               dec.phase = '{id_mode: idm, step: nfc_pkg::STEP_U1};
            end
         end
         nfc_pkg::STEP_U1: begin
            if (ca == nfc_pkg::UNLOCK_ADDR2 && cd == nfc_pkg::CMD_UNLOCK2) begin
               dec.phase = '{id_mode: idm, step: nfc_pkg::STEP_U2};
            end
         end
         nfc_pkg::STEP_U2: begin
            if (ca == nfc_pkg::UNLOCK_ADDR1) begin
               if (cd == nfc_pkg::CMD_PROGRAM) begin
                  dec.phase = '{id_mode: idm, step: nfc_pkg::STEP_PROG};
               end else if (cd == nfc_pkg::CMD_ERASE) begin
                  dec.phase = '{id_mode: idm, step: nfc_pkg::STEP_E1};
               end else if (cd == nfc_pkg::CMD_ID_ENTRY) begin
                  dec.phase = '{id_mode: 1'b1, step: nfc_pkg::STEP_READ};
               end
            end
         end
         nfc_pkg::STEP_PROG: begin
            dec.start = 1'b1;
            dec.op = nfc_pkg::OP_PROG;
         end
         nfc_pkg::STEP_E1: begin
            if (ca == nfc_pkg::UNLOCK_ADDR1 && cd == nfc_pkg::CMD_UNLOCK1) begin
               dec.phase = '{id_mode: idm, step: nfc_pkg::STEP_E2};
            end
         end
         nfc_pkg::STEP_E2: begin
            if (ca == nfc_pkg::UNLOCK_ADDR2 && cd == nfc_pkg::CMD_UNLOCK2) begin
               dec.phase = '{id_mode: idm, step: nfc_pkg::STEP_E3};
            end
         end
         nfc_pkg::STEP_E3: begin
            if (cd == nfc_pkg::CMD_SECT_ERASE) begin
               dec.start = 1'b1;
               dec.op = nfc_pkg::OP_SECTOR;
            end else if (cd == nfc_pkg::CMD_BLOCK_ERASE) begin
               dec.start = 1'b1;
               dec.op = nfc_pkg::OP_BLOCK;
            end else if (cd == nfc_pkg::CMD_CHIP_ERASE && ca == nfc_pkg::UNLOCK_ADDR1) begin
               dec.start = 1'b1;
               dec.op = nfc_pkg::OP_CHIP;
            end
         end
         default: begin
            dec.phase = '{id_mode: 1'b0, step: nfc_pkg::STEP_READ};
         end
      endcase
   end

endmodule

/* rtl/nor_flash_command_decoder.sv */
// ----------------------------------------------------------------------------
// NOR flash command decoder
// Word-bus flash device model: command sequences, ID mode, timed program and
// erase operations over an on-chip word array.
// ----------------------------------------------------------------------------
// Each request beat is a bus read, a bus write or one time tick, and produces
// exactly one response beat carrying read_data and busy_res. A write, a tick or
// a read of status or ID codes is answered from a registered response; a read
// of the array first passes through the registered array read port. The tick
// that completes a word program adds a read-modify-write of the word. The tick
// that completes an erase walks the erased region one word per cycle through
// the array write port (a whole chip for a chip erase) before it is answered.
// One request is in flight at a time; a new request can enter at the
// edge at which the previous response beat is taken.
// After reset the block sweeps the whole array to all ones, one word per
// cycle, with req_stall high; CSR writes are taken during that time. If
// rsp_stall is held, the response holds and req_stall rises so no further
// request is taken until the beat is delivered.
// ----------------------------------------------------------------------------
module nor_flash_command_decoder #(
   parameter int ARRAY_WORDS = 524288,
   parameter int SECTOR_WORDS = 2048,
   parameter int BLOCK_WORDS = 32768
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [nfc_pkg::KIND_W-1:0]          req_kind,
   input  logic [nfc_pkg::WADDR_W-1:0]         req_word_address,
   input  logic [nfc_pkg::WORD_W-1:0]          req_write_data,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [nfc_pkg::WORD_W-1:0]          rsp_read_data,
   output logic                                rsp_busy_res,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [nfc_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [nfc_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [nfc_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   localparam int AW = $clog2(ARRAY_WORDS);
   localparam int SECT_SPAN = (SECTOR_WORDS < ARRAY_WORDS) ? SECTOR_WORDS : ARRAY_WORDS;
   localparam int BLOCK_SPAN = (BLOCK_WORDS < ARRAY_WORDS) ? BLOCK_WORDS : ARRAY_WORDS;
   localparam logic [AW-1:0] SECT_MASK = AW'(SECT_SPAN - 1);
   localparam logic [AW-1:0] BLOCK_MASK = AW'(BLOCK_SPAN - 1);
   localparam logic [AW-1:0] LAST_WORD = AW'(ARRAY_WORDS - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_READ,
      ST_PROG,
      ST_FILL
   } state_type;

   state_type                       state_ff, state_in;
   nfc_pkg::phase_type              phase_ff, phase_in;
   logic [nfc_pkg::TICKS_W-1:0]     busy_rem_ff, busy_rem_in;
   logic [1:0]                      pend_op_ff, pend_op_in;
   logic [AW-1:0]                   pend_addr_ff, pend_addr_in;
   logic [nfc_pkg::WORD_W-1:0]      pend_word_ff, pend_word_in;
   logic                            toggle_ff, toggle_in;
   logic [AW-1:0]                   fill_addr_ff, fill_addr_in;
   logic [AW-1:0]                   fill_last_ff, fill_last_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic [nfc_pkg::WORD_W-1:0]      rsp_data_ff, rsp_data_in;
   logic                            rsp_busy_ff, rsp_busy_in;

   logic [7:0]                      manuf_ff;
   logic [15:0]                     device_ff;
   logic [15:0]                     prog_ticks_ff;
   logic [nfc_pkg::TICKS_W-1:0]     sect_ticks_ff;
   logic [nfc_pkg::TICKS_W-1:0]     block_ticks_ff;
   logic [nfc_pkg::TICKS_W-1:0]     chip_ticks_ff;

   logic                            accept;
   logic                            busy;
   logic [AW-1:0]                   req_addr;
   logic [2:0]                      csr_index;
   logic                            csr_wr;
   nfc_pkg::dec_type                dec;
   logic [nfc_pkg::TICKS_W-1:0]     op_ticks;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   logic [nfc_pkg::WORD_W-1:0]      mem_wdata;
   logic [AW-1:0]                   mem_raddr;
   logic [nfc_pkg::WORD_W-1:0]      mem_rdata;

   nfc_decode u_decode (
      .phase        (phase_ff),
      .word_address (req_word_address),
      .write_data   (req_write_data),
      .dec          (dec)
   );

   nfc_array #(
      .ARRAY_WORDS (ARRAY_WORDS)
   ) u_array (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   assign req_addr = AW'(req_word_address);
   assign busy = (busy_rem_ff != '0);
   assign req_stall = !(state_ff == ST_IDLE && (!rsp_valid_ff || !rsp_stall));
   assign accept = req_valid && !req_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_busy_res = rsp_busy_ff;

   assign csr_pready = 1'b1;
   assign csr_index = csr_paddr[4:2];
   assign csr_wr = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_index)
         nfc_pkg::CSR_MANUF:       csr_prdata = 32'(manuf_ff);
         nfc_pkg::CSR_DEVICE:      csr_prdata = 32'(device_ff);
         nfc_pkg::CSR_PROG_TICKS:  csr_prdata = 32'(prog_ticks_ff);
         nfc_pkg::CSR_SECT_TICKS:  csr_prdata = 32'(sect_ticks_ff);
         nfc_pkg::CSR_BLOCK_TICKS: csr_prdata = 32'(block_ticks_ff);
         nfc_pkg::CSR_CHIP_TICKS:  csr_prdata = 32'(chip_ticks_ff);
         default:                  csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         manuf_ff <= 8'd191;
         device_ff <= 16'd10113;
         prog_ticks_ff <= 16'd20;
         sect_ticks_ff <= 24'd25000;
         block_ticks_ff <= 24'd25000;
         chip_ticks_ff <= 24'd100000;
      end else if (csr_wr) begin
         unique case (csr_index)
            nfc_pkg::CSR_MANUF:       manuf_ff <= csr_pwdata[7:0];
            nfc_pkg::CSR_DEVICE:      device_ff <= csr_pwdata[15:0];
            nfc_pkg::CSR_PROG_TICKS:  prog_ticks_ff <= csr_pwdata[15:0];
            nfc_pkg::CSR_SECT_TICKS:  sect_ticks_ff <= csr_pwdata[23:0];
            nfc_pkg::CSR_BLOCK_TICKS: block_ticks_ff <= csr_pwdata[23:0];
            nfc_pkg::CSR_CHIP_TICKS:  chip_ticks_ff <= csr_pwdata[23:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (dec.op)
         nfc_pkg::OP_PROG:   op_ticks = 24'(prog_ticks_ff);
         nfc_pkg::OP_SECTOR: op_ticks = sect_ticks_ff;
         nfc_pkg::OP_BLOCK:  op_ticks = block_ticks_ff;
         default:            op_ticks = chip_ticks_ff;
      endcase
   end

   assign mem_raddr = (req_kind == nfc_pkg::KIND_TICK) ? pend_addr_ff : req_addr;

   always_comb begin
      mem_we = 1'b0;
      mem_waddr = fill_addr_ff;
      mem_wdata = '1;
      unique case (state_ff)
         ST_CLEAR, ST_FILL: mem_we = 1'b1;
         ST_PROG: begin
            mem_we = 1'b1;
            mem_waddr = pend_addr_ff;
            mem_wdata = mem_rdata & pend_word_ff;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      phase_in = phase_ff;
      busy_rem_in = busy_rem_ff;
      pend_op_in = pend_op_ff;
      pend_addr_in = pend_addr_ff;
      pend_word_in = pend_word_ff;
      toggle_in = toggle_ff;
      fill_addr_in = fill_addr_ff;
      fill_last_in = fill_last_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_data_in = rsp_data_ff;
      rsp_busy_in = rsp_busy_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == LAST_WORD) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_busy_in = busy;
               priority case (req_kind)
                  nfc_pkg::KIND_READ: begin
                     if (busy) begin
                        rsp_data_in = {8'd0,
                                       (pend_op_ff == nfc_pkg::OP_PROG) & ~pend_word_ff[7],
                                       toggle_ff, 6'd0};
                        toggle_in = !toggle_ff;
                     end else if (phase_ff.id_mode) begin
                        rsp_data_in = req_word_address[0] ? device_ff : 16'(manuf_ff);
                     end else begin
                        rsp_valid_in = 1'b0;
                        state_in = ST_READ;
                     end
                  end
                  nfc_pkg::KIND_WRITE: begin
                     if (!busy) begin
                        phase_in = dec.phase;
                        if (dec.start) begin
                           pend_op_in = dec.op;
                           pend_addr_in = req_addr;
                           pend_word_in = (dec.op == nfc_pkg::OP_PROG) ? req_write_data : '0;
                           busy_rem_in = (op_ticks == '0) ? 24'd1 : op_ticks;
                           rsp_busy_in = 1'b1;
                        end
                     end
                  end
                  nfc_pkg::KIND_TICK: begin
                     if (busy) begin
                        busy_rem_in = busy_rem_ff - 1'b1;
                        if (busy_rem_ff == 24'd1) begin
                           rsp_busy_in = 1'b0;
                           rsp_valid_in = 1'b0;
                           unique case (pend_op_ff)
                              nfc_pkg::OP_PROG: state_in = ST_PROG;
                              nfc_pkg::OP_SECTOR: begin
                                 fill_addr_in = pend_addr_ff & ~SECT_MASK;
                                 fill_last_in = pend_addr_ff | SECT_MASK;
                                 state_in = ST_FILL;
                              end
                              nfc_pkg::OP_BLOCK: begin
                                 fill_addr_in = pend_addr_ff & ~BLOCK_MASK;
                                 fill_last_in = pend_addr_ff | BLOCK_MASK;
                                 state_in = ST_FILL;
                              end
                              default: begin
                                 fill_addr_in = '0;
                                 fill_last_in = LAST_WORD;
                                 state_in = ST_FILL;
                              end
                           endcase
                        end
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            rsp_valid_in = 1'b1;
            rsp_data_in = mem_rdata;
            rsp_busy_in = 1'b0;
            state_in = ST_IDLE;
         end
         ST_PROG: begin
            rsp_valid_in = 1'b1;
            rsp_data_in = '0;
            rsp_busy_in = 1'b0;
            state_in = ST_IDLE;
         end
         default: begin
            fill_addr_in = fill_addr_ff + 1'b1;
            if (fill_addr_ff == fill_last_ff) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_busy_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         phase_ff <= '{id_mode: 1'b0, step: nfc_pkg::STEP_READ};
         busy_rem_ff <= '0;
         pend_op_ff <= nfc_pkg::OP_PROG;
         pend_addr_ff <= '0;
         pend_word_ff <= '0;
         toggle_ff <= 1'b0;
         fill_addr_ff <= '0;
         fill_last_ff <= LAST_WORD;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         phase_ff <= phase_in;
         busy_rem_ff <= busy_rem_in;
         pend_op_ff <= pend_op_in;
         pend_addr_ff <= pend_addr_in;
         pend_word_ff <= pend_word_in;
         toggle_ff <= toggle_in;
         fill_addr_ff <= fill_addr_in;
         fill_last_ff <= fill_last_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
      rsp_busy_ff <= rsp_busy_in;
   end

   a_stall_when_working: assert property (@(posedge clock) disable iff (reset)
      (state_ff != ST_IDLE) |-> req_stall)
      else $error("request taken outside idle state");

   a_busy_in_read_phase: assert property (@(posedge clock) disable iff (reset)
      busy |-> (phase_ff.step == nfc_pkg::STEP_READ && !phase_ff.id_mode))
      else $error("command phase advanced while an operation is busy");

   a_fill_not_busy: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FILL || state_ff == ST_PROG) |-> !busy)
      else $error("array update while count still running");

   a_write_outside_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff != ST_IDLE && state_ff != ST_READ))
      else $error("array write in a read or idle state");

endmodule
